// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the zero-suppress framer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked from one clock to the next, masked while in reset.
`define PZSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("pzsf check failed");

// Checked on the edge after a reset cycle, not masked by reset.
`define PZSF_ASSERT_AFTER_RESET(lbl, cons) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error("pzsf reset check failed");

`endif

// ----- src/pzsf_pkg.sv -----
// ----------------------------------------------------------------------------
// pzsf_pkg
// Shared constants, job record and CRC helper for the zero-suppress framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pzsf_pkg;

    localparam int CHIP_COLUMNS = 64;
    localparam int JOB_WORDS    = 6;     // most words one input beat can cause
    localparam int QUEUE_DEPTH  = 4;
    localparam int NLIT_W       = $clog2(JOB_WORDS + 1);
    localparam int IDX_W        = $clog2(JOB_WORDS + 2);

    localparam logic [31:0] CRC_POLY      = 32'h04C1_1DB7;
    localparam logic [15:0] DATA_FLAG     = 16'h8000;
    localparam logic [9:0]  ROW_PAIR_MASK = 10'h3FE;

    // input kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ZSD_TYPE   = 2'd0;
    localparam logic [1:0] REG_CHIP_TYPE  = 2'd1;
    localparam logic [1:0] REG_GHOST_TYPE = 2'd2;
    localparam logic [1:0] REG_LEGACY     = 2'd3;

    typedef logic [15:0] word_t;

    // One unit of work for the back end: literal words, then optionally the CRC.
    typedef struct packed {
        word_t [JOB_WORDS-1:0] words;
        logic  [NLIT_W-1:0]    n_lit;
        logic                  is_end;       // append the two CRC words
        logic                  crc_restart;  // a start came before this job
    } job_t;

    // CRC-32, MSB first, fed one big-endian 16-bit word
    function automatic logic [31:0] crc_word(input logic [31:0] crc_in, input word_t w);
        logic [31:0] c;
        c = crc_in ^ {w, 16'h0000};
        for (int i = 0; i < 16; i++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/pzsf_front.sv -----
// ----------------------------------------------------------------------------
// pzsf_front
// Accepts beats, holds headers and row state, turns hit pixels and ends into jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pzsf_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [5:0]          s_module_id,
    input  logic [1:0]          s_chip_index,
    input  logic [15:0]         s_trigger_low,
    input  logic [15:0]         s_readout_frame_nr,
    input  logic [9:0]          s_pixel_row,
    input  logic [5:0]          s_pixel_column,
    input  logic [7:0]          s_pixel_value,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [4:0]          cfg_data,
    input  logic                q_full,
    output logic                job_valid,
    output pzsf_pkg::job_t      job
);

    logic [4:0]  zsd_type_reg,   zsd_type_next;
    logic [2:0]  chip_type_reg,  chip_type_next;
    logic [4:0]  ghost_type_reg, ghost_type_next;
    logic        legacy_reg,     legacy_next;

    logic [31:0] hdr_a_reg, hdr_a_next;
    logic [31:0] hdr_b_reg, hdr_b_next;
    logic [31:0] ghost_reg, ghost_next;

    logic        header_sent_reg,   header_sent_next;
    logic [9:0]  current_row_reg,   current_row_next;
    logic        row_opened_reg,    row_opened_next;
    logic [15:0] last_row_word_reg, last_row_word_next;
    logic        parity_reg,        parity_next;
    logic        clear_pending_reg, clear_pending_next;

    logic        accept;
    logic        hit;
    logic        new_row;
    logic [15:0] row_word;
    logic [15:0] data_word;
    logic [2:0]  slot;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    assign hit = (s_kind == pzsf_pkg::KIND_PIXEL) && (s_pixel_value != 8'd0) &&
                 ({1'b0, s_pixel_column} < 7'(pzsf_pkg::CHIP_COLUMNS));
    assign new_row   = !row_opened_reg || (s_pixel_row != current_row_reg);
    assign row_word  = {1'b0, s_pixel_row & pzsf_pkg::ROW_PAIR_MASK, 5'b00000};
    assign data_word = pzsf_pkg::DATA_FLAG |
                       {1'b0, s_pixel_row[0], s_pixel_column, s_pixel_value};

    // job record for the current beat
    always_comb begin
        job       = '0;
        job_valid = 1'b0;
        slot      = 3'd0;
        job.crc_restart = clear_pending_reg;
        if (s_kind == pzsf_pkg::KIND_PIXEL) begin
            job_valid = accept && hit;
            if (!header_sent_reg) begin
                job.words[0] = hdr_a_reg[31:16];
                job.words[1] = hdr_a_reg[15:0];
                job.words[2] = hdr_b_reg[31:16];
                job.words[3] = hdr_b_reg[15:0];
                slot = 3'd4;
            end
            if (new_row) begin
                job.words[slot] = row_word;
                slot = slot + 3'd1;
            end
            job.words[slot] = data_word;
            job.n_lit = pzsf_pkg::NLIT_W'(slot + 3'd1);
        end else if (s_kind == pzsf_pkg::KIND_END) begin
            job_valid  = accept;
            job.is_end = 1'b1;
            if (header_sent_reg) begin
                job.words[0] = last_row_word_reg;
                job.n_lit    = pzsf_pkg::NLIT_W'(parity_reg);
            end else if (legacy_reg) begin
                job.words[0] = ghost_reg[31:16];
                job.words[1] = ghost_reg[15:0];
                job.n_lit    = pzsf_pkg::NLIT_W'(2);
            end else begin
                job.words[0] = hdr_a_reg[31:16];
                job.words[1] = hdr_a_reg[15:0];
                job.words[2] = hdr_b_reg[31:16];
                job.words[3] = hdr_b_reg[15:0];
                job.n_lit    = pzsf_pkg::NLIT_W'(4);
            end
        end
    end

    // configuration writes
    always_comb begin
        zsd_type_next   = zsd_type_reg;
        chip_type_next  = chip_type_reg;
        ghost_type_next = ghost_type_reg;
        legacy_next     = legacy_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pzsf_pkg::REG_ZSD_TYPE:   zsd_type_next   = cfg_data;
                pzsf_pkg::REG_CHIP_TYPE:  chip_type_next  = cfg_data[2:0];
                pzsf_pkg::REG_GHOST_TYPE: ghost_type_next = cfg_data;
                pzsf_pkg::REG_LEGACY:     legacy_next     = cfg_data[0];
                default: ;
            endcase
        end
    end

    // frame state
    always_comb begin
        hdr_a_next         = hdr_a_reg;
        hdr_b_next         = hdr_b_reg;
        ghost_next         = ghost_reg;
        header_sent_next   = header_sent_reg;
        current_row_next   = current_row_reg;
        row_opened_next    = row_opened_reg;
        last_row_word_next = last_row_word_reg;
        parity_next        = parity_reg;
        clear_pending_next = clear_pending_reg;
        if (accept) begin
            case (s_kind)
                pzsf_pkg::KIND_START: begin
                    hdr_a_next = {zsd_type_reg, 1'b0, s_module_id, 1'b1, 1'b0,
                                  s_chip_index, s_trigger_low};
                    hdr_b_next = {chip_type_reg, 5'b00000, s_module_id,
                                  s_chip_index, s_readout_frame_nr};
                    ghost_next = {ghost_type_reg, 1'b0, s_module_id, 2'b00,
                                  s_chip_index, s_trigger_low};
                    header_sent_next   = 1'b0;
                    current_row_next   = '0;
                    row_opened_next    = 1'b0;
                    last_row_word_next = '0;
                    parity_next        = 1'b0;
                    clear_pending_next = 1'b1;
                end
                pzsf_pkg::KIND_PIXEL: begin
                    if (hit) begin
                        header_sent_next   = 1'b1;
                        clear_pending_next = 1'b0;
                        // headers are four words, so only the row word sways parity
                        parity_next = parity_reg ^ !new_row;
                        if (new_row) begin
                            current_row_next   = s_pixel_row;
                            row_opened_next    = 1'b1;
                            last_row_word_next = row_word;
                        end
                    end
                end
                pzsf_pkg::KIND_END: begin
                    header_sent_next   = 1'b0;
                    current_row_next   = '0;
                    row_opened_next    = 1'b0;
                    last_row_word_next = '0;
                    parity_next        = 1'b0;
                    clear_pending_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zsd_type_reg      <= 5'd5;
            chip_type_reg     <= 3'd5;
            ghost_type_reg    <= 5'd0;
            legacy_reg        <= 1'b0;
            hdr_a_reg         <= '0;
            hdr_b_reg         <= '0;
            ghost_reg         <= '0;
            header_sent_reg   <= 1'b0;
            current_row_reg   <= '0;
            row_opened_reg    <= 1'b0;
            last_row_word_reg <= '0;
            parity_reg        <= 1'b0;
            clear_pending_reg <= 1'b0;
        end else begin
            zsd_type_reg      <= zsd_type_next;
            chip_type_reg     <= chip_type_next;
            ghost_type_reg    <= ghost_type_next;
            legacy_reg        <= legacy_next;
            hdr_a_reg         <= hdr_a_next;
            hdr_b_reg         <= hdr_b_next;
            ghost_reg         <= ghost_next;
            header_sent_reg   <= header_sent_next;
            current_row_reg   <= current_row_next;
            row_opened_reg    <= row_opened_next;
            last_row_word_reg <= last_row_word_next;
            parity_reg        <= parity_next;
            clear_pending_reg <= clear_pending_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/pzsf_queue.sv -----
// ----------------------------------------------------------------------------
// pzsf_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pzsf_queue #(
    parameter int DEPTH = pzsf_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pzsf_pkg::job_t push_job,
    output logic           full,
    output logic           q_valid,
    output pzsf_pkg::job_t q_job,
    input  logic           pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pzsf_pkg::job_t   store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/pzsf_back.sv -----
// ----------------------------------------------------------------------------
// pzsf_back
// Streams each job's words one a cycle unless stalled; running CRC, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pzsf_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  pzsf_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [15:0]    m_frame_word,
    output logic           m_frame_last
);

    logic [pzsf_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]                crc_reg, crc_next;
    logic                       m_valid_reg, m_valid_next;
    logic [15:0]                m_word_reg, m_word_next;
    logic                       m_last_reg, m_last_next;

    logic                       out_free;
    logic                       emit;
    logic [31:0]                crc_base;
    logic [pzsf_pkg::IDX_W-1:0] n_lit;
    logic [pzsf_pkg::IDX_W-1:0] total;
    logic                       in_lit;
    logic                       is_crc_hi;
    logic                       last_word;
    logic [15:0]                word;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = out_free && q_valid;
    assign n_lit     = pzsf_pkg::IDX_W'(q_job.n_lit);
    assign total     = n_lit + (q_job.is_end ? pzsf_pkg::IDX_W'(2) : '0);
    assign in_lit    = idx_reg < n_lit;
    assign is_crc_hi = idx_reg == n_lit;
    assign last_word = idx_reg == total - 1'b1;
    assign q_pop     = emit && last_word;

    // a start since the previous job restarts the checksum from zero
    assign crc_base = (idx_reg == '0 && q_job.crc_restart) ? '0 : crc_reg;

    always_comb begin
        if (in_lit) begin
            word = q_job.words[idx_reg];
        end else if (is_crc_hi) begin
            word = crc_base[31:16];
        end else begin
            word = crc_base[15:0];
        end
    end

    always_comb begin
        idx_next     = idx_reg;
        crc_next     = crc_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        m_last_next  = m_last_reg;
        if (out_free) begin
            m_valid_next = q_valid;
        end
        if (emit) begin
            m_word_next = word;
            m_last_next = q_job.is_end && !in_lit && !is_crc_hi;
            idx_next    = last_word ? '0 : idx_reg + 1'b1;
            if (in_lit) begin
                crc_next = pzsf_pkg::crc_word(crc_base, word);
            end else if (is_crc_hi) begin
                crc_next = crc_base;
            end else begin
                crc_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            crc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_word = m_word_reg;
    assign m_frame_last = m_last_reg;

endmodule

`default_nettype wire

// ----- src/pixel_zero_suppress_framer_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_zero_suppress_framer_unit
// Zero-suppressed readout framer for one 64-column pixel chip.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_*       in   s_valid / s_ready      kind, header fields, row, column, value
//  m_*       out  m_valid / m_ready      frame_word (16 b), frame_last
//  cfg_*     in   cfg_valid / cfg_ready  cfg_index (2 b), cfg_data (5 b)
//
//  Input beats are taken one a cycle while the job queue has room; starts,
//  zero pixels and unknown kinds are taken and emit nothing.
//  The output side sends one 16-bit word a cycle while m_ready allows, so a
//  hit pixel makes one to six output words and a frame end two to six; that
//  word port sets the sustained rate. First word passes through the job
//  queue and the output register before it is offered on m_*.
//  Reset is synchronous: control state and config registers return to
//  their reset values at once, no clearing pass.
//  Either side may stall freely: the queue and output register absorb it.
//
`timescale 1ns / 1ps
`default_nettype none

module pixel_zero_suppress_framer_unit #(
    parameter int QUEUE_DEPTH = pzsf_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [5:0]  s_module_id,
    input  logic [1:0]  s_chip_index,
    input  logic [15:0] s_trigger_low,
    input  logic [15:0] s_readout_frame_nr,
    input  logic [9:0]  s_pixel_row,
    input  logic [5:0]  s_pixel_column,
    input  logic [7:0]  s_pixel_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_frame_word,
    output logic        m_frame_last,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    // front -> queue
    logic           job_valid;
    pzsf_pkg::job_t job;
    logic           q_full;

    // queue -> back
    logic           q_valid;
    pzsf_pkg::job_t q_job;
    logic           q_pop;

    // Front end: header capture, row tracking, frame parity, job building.
    pzsf_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_module_id        (s_module_id),
        .s_chip_index       (s_chip_index),
        .s_trigger_low      (s_trigger_low),
        .s_readout_frame_nr (s_readout_frame_nr),
        .s_pixel_row        (s_pixel_row),
        .s_pixel_column     (s_pixel_column),
        .s_pixel_value      (s_pixel_value),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .q_full             (q_full),
        .job_valid          (job_valid),
        .job                (job)
    );

    // Decoupling queue: a burst of hits does not stall the pixel stream at once.
    pzsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_valid),
        .push_job (job),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (q_pop)
    );

    // Back end: word sequencing, CRC-32 over every literal word, output beat.
    pzsf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_job        (q_job),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_word (m_frame_word),
        .m_frame_last (m_frame_last)
    );

endmodule

`default_nettype wire

// ----- src/pzsf_checker.sv -----
// ----------------------------------------------------------------------------
// pzsf_checker
// Port-level checks on the framer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pzsf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_frame_word,
    input  logic        m_frame_last,
    input  logic        cfg_ready
);

    // a stalled output beat keeps its word
    `PZSF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_frame_word) && $stable(m_frame_last))

    // an accepted last beat is never directly followed by another valid last beat
    `PZSF_ASSERT_NEXT(a_last_not_twice, m_valid && m_ready && m_frame_last, !(m_valid && m_frame_last))

    // output register comes out of reset empty
    `PZSF_ASSERT_AFTER_RESET(a_reset_empty, !m_valid)

    // configuration port never back-pressures
    `PZSF_ASSERT_NEXT(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind pixel_zero_suppress_framer_unit pzsf_checker u_pzsf_checker (.*);

`default_nettype wire

// ----- test/pzsf_frame_checker.sv -----
// ----------------------------------------------------------------------------
// pzsf_frame_checker
// Watches the pixel, result and register channels of the framer, builds the
// expected frame words from the accepted pixel beats and compares them, word
// by word, with what leaves the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pzsf_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [5:0]  s_module_id,
    input  logic [1:0]  s_chip_index,
    input  logic [15:0] s_trigger_low,
    input  logic [15:0] s_readout_frame_nr,
    input  logic [9:0]  s_pixel_row,
    input  logic [5:0]  s_pixel_column,
    input  logic [7:0]  s_pixel_value,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_frame_word,
    input  logic        m_frame_last,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,

    output int          mismatches,
    output int          words_waiting,
    output int          words_checked
);

    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } frame_beat_t;

    frame_beat_t expected_words[$];
    frame_beat_t head;

    // register copies
    logic [4:0]  zsd_type_q;
    logic [2:0]  chip_type_q;
    logic [4:0]  ghost_type_q;
    logic        legacy_q;

    // frame state
    logic [31:0] hdr_a, hdr_b, hdr_ghost;
    logic        hdr_out;
    logic [9:0]  open_row;
    logic        row_open;
    logic [15:0] row_word;
    logic        odd_words;
    logic [31:0] crc_acc;

    function automatic logic [31:0] crc_add_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {b, 24'h0};
        for (int i = 0; i < 8; i++)
            r = r[31] ? ((r << 1) ^ pzsf_pkg::CRC_POLY) : (r << 1);
        return r;
    endfunction

    task automatic queue_beat(input logic [15:0] w, input logic l);
        frame_beat_t b;
        b.word = w;
        b.last = l;
        expected_words.insert(expected_words.size(), b);
    endtask

    task automatic push_word(input logic [15:0] w);
        crc_acc   = crc_add_byte(crc_add_byte(crc_acc, w[15:8]), w[7:0]);
        odd_words = ~odd_words;
        queue_beat(w, 1'b0);
    endtask

    task automatic push_long(input logic [31:0] v);
        push_word(v[31:16]);
        push_word(v[15:0]);
    endtask

    task automatic restart_frame();
        hdr_out   = 1'b0;
        open_row  = '0;
        row_open  = 1'b0;
        row_word  = '0;
        odd_words = 1'b0;
        crc_acc   = '0;
    endtask

    task automatic predict_beat(input logic [1:0] kind, input logic [5:0] mod_id,
                                input logic [1:0] chip, input logic [15:0] trig,
                                input logic [15:0] fnr, input logic [9:0] row,
                                input logic [5:0] col, input logic [7:0] val);
        logic [31:0] crc_out;
        case (kind)
            pzsf_pkg::KIND_START: begin
                hdr_a     = {zsd_type_q, 1'b0, mod_id, 1'b1, 1'b0, chip, trig};
                hdr_b     = {chip_type_q, 5'b0, mod_id, chip, fnr};
                hdr_ghost = {ghost_type_q, 1'b0, mod_id, 2'b00, chip, trig};
                restart_frame();
            end
            pzsf_pkg::KIND_PIXEL: begin
                if (val != 8'd0 && int'(col) < pzsf_pkg::CHIP_COLUMNS) begin
                    if (!hdr_out) begin
                        push_long(hdr_a);
                        push_long(hdr_b);
                        hdr_out = 1'b1;
                    end
                    if (!row_open || row != open_row) begin
                        row_word = {1'b0, row & pzsf_pkg::ROW_PAIR_MASK, 5'b0};
                        push_word(row_word);
                        open_row = row;
                        row_open = 1'b1;
                    end
                    push_word(pzsf_pkg::DATA_FLAG | {1'b0, row[0], col, val});
                end
            end
            pzsf_pkg::KIND_END: begin
                if (hdr_out) begin
                    // pad to 32 bits with a repeat of the row start
                    if (odd_words)
                        push_word(row_word);
                end else if (legacy_q) begin
                    push_long(hdr_ghost);
                end else begin
                    push_long(hdr_a);
                    push_long(hdr_b);
                end
                crc_out = crc_acc;
                queue_beat(crc_out[31:16], 1'b0);
                queue_beat(crc_out[15:0], 1'b1);
                restart_frame();
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            zsd_type_q    = 5'd5;
            chip_type_q   = 3'd5;
            ghost_type_q  = 5'd0;
            legacy_q      = 1'b0;
            hdr_a         = '0;
            hdr_b         = '0;
            hdr_ghost     = '0;
            restart_frame();
            expected_words.delete();
            mismatches    = 0;
            words_checked = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected frame word, expected none, actual %04h last %0b",
                             $time, m_frame_word, m_frame_last);
                end else begin
                    head = expected_words.pop_front();
                    if (m_frame_word !== head.word) begin
                        mismatches++;
                        $display("%0t ns: frame_word mismatch, expected %04h, actual %04h",
                                 $time, head.word, m_frame_word);
                    end
                    if (m_frame_last !== head.last) begin
                        mismatches++;
                        $display("%0t ns: frame_last mismatch, expected %0b, actual %0b",
                                 $time, head.last, m_frame_last);
                    end
                end
                words_checked++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pzsf_pkg::REG_ZSD_TYPE:   zsd_type_q   = cfg_data;
                    pzsf_pkg::REG_CHIP_TYPE:  chip_type_q  = cfg_data[2:0];
                    pzsf_pkg::REG_GHOST_TYPE: ghost_type_q = cfg_data;
                    pzsf_pkg::REG_LEGACY:     legacy_q     = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_beat(s_kind, s_module_id, s_chip_index, s_trigger_low,
                             s_readout_frame_nr, s_pixel_row, s_pixel_column,
                             s_pixel_value);
        end
        words_waiting = expected_words.size();
    end

endmodule

// ----- test/pixel_zero_suppress_framer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// pixel_zero_suppress_framer_unit_tb
// Drives zero-suppressed readout frames through the framer: a directed set of
// corner frames, then random frames across several register settings, with
// random back-pressure and one long output stall. Checking is done by
// pzsf_frame_checker, instantiated beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_zero_suppress_framer_unit_tb;

    localparam int          CLK_HALF        = 6;      // 12 ns period
    localparam int          RESET_CYCLES    = 9;
    localparam int          ITEM_TARGET     = 170;    // pixel-channel beats, whole run
    localparam int          QUIET_TAIL      = 35;     // last beats sent with no idling
    localparam int          HOLD_OFF_CYCLES = 80;     // long receiver stall
    localparam int          DRAIN_CYCLES    = 12;     // settle time after the last word
    localparam int          CYCLE_LIMIT     = 300000;
    localparam logic [1:0]  KIND_UNUSED     = 2'd3;   // undefined kind, dropped by the block

    logic        aclk;
    logic        aresetn;

    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [5:0]  s_module_id;
    logic [1:0]  s_chip_index;
    logic [15:0] s_trigger_low;
    logic [15:0] s_readout_frame_nr;
    logic [9:0]  s_pixel_row;
    logic [5:0]  s_pixel_column;
    logic [7:0]  s_pixel_value;

    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_frame_word;
    logic        m_frame_last;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_data;

    int mismatches;
    int pending_words;
    int words_checked;

    // run bookkeeping
    int cycle_count   = 0;
    int beats_sent    = 0;
    int frames_sent   = 0;
    int config_phases = 0;

    // idling controls; m_gaps_on and hold_off_req are shared with the ready process
    bit s_gaps_on    = 1'b1;
    bit m_gaps_on    = 1'b1;
    bit hold_off_req = 1'b0;

    pixel_zero_suppress_framer_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_module_id        (s_module_id),
        .s_chip_index       (s_chip_index),
        .s_trigger_low      (s_trigger_low),
        .s_readout_frame_nr (s_readout_frame_nr),
        .s_pixel_row        (s_pixel_row),
        .s_pixel_column     (s_pixel_column),
        .s_pixel_value      (s_pixel_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_word       (m_frame_word),
        .m_frame_last       (m_frame_last),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    pzsf_frame_checker u_frame_chk (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_module_id        (s_module_id),
        .s_chip_index       (s_chip_index),
        .s_trigger_low      (s_trigger_low),
        .s_readout_frame_nr (s_readout_frame_nr),
        .s_pixel_row        (s_pixel_row),
        .s_pixel_column     (s_pixel_column),
        .s_pixel_value      (s_pixel_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_word       (m_frame_word),
        .m_frame_last       (m_frame_last),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatches),
        .words_waiting      (pending_words),
        .words_checked      (words_checked)
    );

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run: every beat behind the longest
    // random gap, every word behind the longest random stall, plus the hold-off.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t ns: timed out after %0d cycles, %0d words still due",
                 $time, cycle_count, pending_words);
        $display("pixel_zero_suppress_framer_unit regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, one long hold-off on request, and no
    // stalls at all once m_gaps_on drops. At most one assignment to m_ready per
    // falling edge.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                // counted here so the sender keeps offering beats meanwhile
                m_ready      <= 1'b0;
                hold_off_req  = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
            end else if (m_gaps_on && $urandom_range(0, 7) == 0) begin
                stall    = $urandom_range(1, 13);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel channel helpers
    // ------------------------------------------------------------------------

    // One beat on the pixel channel, maybe after a random idle burst. Valid
    // is left high on return; the next beat or drain_frames decides.
    task automatic send_beat(input logic [1:0] kind, input logic [5:0] mod_id,
                             input logic [1:0] chip, input logic [15:0] trig,
                             input logic [15:0] fnr, input logic [9:0] row,
                             input logic [5:0] col, input logic [7:0] val);
        int gap;
        if (s_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid            <= 1'b1;
        s_kind             <= kind;
        s_module_id        <= mod_id;
        s_chip_index       <= chip;
        s_trigger_low      <= trig;
        s_readout_frame_nr <= fnr;
        s_pixel_row        <= row;
        s_pixel_column     <= col;
        s_pixel_value      <= val;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    // Unused fields of each kind carry random junk, which must be ignored.
    task automatic send_start(input logic [5:0] mod_id, input logic [1:0] chip,
                              input logic [15:0] trig, input logic [15:0] fnr);
        send_beat(pzsf_pkg::KIND_START, mod_id, chip, trig, fnr,
                  10'($urandom_range(0, 1023)), 6'($urandom_range(0, 63)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_pixel(input logic [9:0] row, input logic [5:0] col,
                              input logic [7:0] val);
        send_beat(pzsf_pkg::KIND_PIXEL, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  row, col, val);
    endtask

    task automatic send_end();
        send_beat(pzsf_pkg::KIND_END, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  10'($urandom_range(0, 1023)), 6'($urandom_range(0, 63)),
                  8'($urandom_range(0, 255)));
        frames_sent++;
    endtask

    task automatic send_noise();
        send_beat(KIND_UNUSED, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  10'($urandom_range(0, 1023)), 6'($urandom_range(0, 63)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_start();
        send_start(6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    // Drop valid, wait for every expected word, then give the block time to
    // swallow any trailing beat that makes no words (a start, a zero pixel).
    task automatic drain_frames();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Register channel: called only with the block drained
    // ------------------------------------------------------------------------
    task automatic put_reg(input logic [1:0] idx, input logic [4:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Upper data bits are sent as given; the narrow registers keep the low ones.
    task automatic write_config(input logic [4:0] zsd, input logic [4:0] chip,
                                input logic [4:0] ghost, input logic [4:0] legacy);
        put_reg(pzsf_pkg::REG_ZSD_TYPE,   zsd);
        put_reg(pzsf_pkg::REG_CHIP_TYPE,  chip);
        put_reg(pzsf_pkg::REG_GHOST_TYPE, ghost);
        put_reg(pzsf_pkg::REG_LEGACY,     legacy);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        config_phases++;
    endtask

    // ------------------------------------------------------------------------
    // One random frame: mostly a clean scan (start, pixels in row order with
    // plenty of zeros, end), occasionally a missing start or end, a stray
    // undefined kind or an out-of-order pixel.
    // ------------------------------------------------------------------------
    task automatic random_frame();
        int        n_pix;
        int        row;
        int        col;
        int        pick;
        logic [7:0] val;
        row = $urandom_range(0, 1023);
        col = -1;
        if ($urandom_range(0, 9) != 0)
            send_random_start();
        n_pix = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 10);
        for (int i = 0; i < n_pix; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_noise();
            end else if (pick == 1) begin
                send_pixel(10'($urandom_range(0, 1023)), 6'($urandom_range(0, 63)),
                           8'($urandom_range(0, 255)));
            end else begin
                col += $urandom_range(1, 24);
                if (col > 63) begin
                    // next row, sometimes skipping a few
                    row = (row + $urandom_range(1, 3)) % 1024;
                    col = col % 64;
                end
                val = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                send_pixel(10'(row), 6'(col), val);
            end
        end
        if ($urandom_range(0, 9) != 0)
            send_end();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_kind             = pzsf_pkg::KIND_START;
        s_module_id        = '0;
        s_chip_index       = '0;
        s_trigger_low      = '0;
        s_readout_frame_nr = '0;
        s_pixel_row        = '0;
        s_pixel_column     = '0;
        s_pixel_value      = '0;
        cfg_valid          = 1'b0;
        cfg_index          = pzsf_pkg::REG_ZSD_TYPE;
        cfg_data           = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed corners, reset register values ---
        // pixel and end with no start: all-zero held headers
        send_pixel(10'd0, 6'd0, 8'h81);
        send_end();
        // end straight after end: empty frame, full header
        send_end();
        // extreme header fields; undefined kind and a zero pixel are dropped;
        // row changes by one inside a row pair; odd word count gets padded
        send_start(6'd63, 2'd3, 16'hFFFF, 16'hFFFF);
        send_noise();
        send_pixel(10'd1023, 6'd63, 8'd0);
        send_pixel(10'd1023, 6'd63, 8'd255);
        send_pixel(10'd1023, 6'd0, 8'd1);
        send_pixel(10'd1022, 6'd5, 8'h80);
        send_pixel(10'd0, 6'd63, 8'h7F);
        send_end();
        // all-zero header fields; even word count, no pad
        send_start(6'd0, 2'd0, 16'h0000, 16'h0000);
        send_pixel(10'd5, 6'd1, 8'h7F);
        send_end();
        // empty frame after a start
        send_start(6'h2A, 2'd1, 16'h5A5A, 16'hA5A5);
        send_end();
        drain_frames();

        // legacy mode: empty frame gets the ghost header, busy frame does not
        write_config(5'd0, 5'd0, 5'd31, 5'd1);
        send_start(6'd63, 2'd3, 16'hFFFF, 16'hFFFF);
        send_end();
        send_start(6'h15, 2'd2, 16'h1234, 16'hFEDC);
        send_pixel(10'd512, 6'd32, 8'hFF);
        send_end();
        drain_frames();

        // --- random frames over a series of register settings ---
        phase = 0;
        while (beats_sent < ITEM_TARGET) begin
            drain_frames();
            case (phase)
                0:       write_config(5'd0, 5'd0, 5'd0, 5'd0);
                1:       write_config(5'd31, 5'd31, 5'd31, 5'd31);
                default: write_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                                      5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            endcase

            if (phase == 2) begin
                // long output stall while a dense frame keeps coming, so the
                // job queue fills and the pixel channel backs up
                s_gaps_on    = 1'b0;
                hold_off_req = 1'b1;
                send_random_start();
                for (int i = 0; i < 16; i++)
                    send_pixel(10'(300 + i / 4), 6'((i % 4) * 16), 8'($urandom_range(1, 255)));
                send_end();
                s_gaps_on = 1'b1;
            end

            for (int f = 0; f < 4 && beats_sent < ITEM_TARGET; f++) begin
                // the tail of the run goes at full rate on both sides
                if (beats_sent >= ITEM_TARGET - QUIET_TAIL) begin
                    s_gaps_on = 1'b0;
                    m_gaps_on = 1'b0;
                end
                random_frame();
            end
            phase++;
        end

        // close whatever frame is open so its words come out
        send_end();
        drain_frames();

        $display("%0d pixel-channel beats, %0d frames closed, %0d frame words checked",
                 beats_sent, frames_sent, words_checked);
        $display("%0d register settings, incl. legacy ghost headers and a %0d-cycle stall",
                 config_phases, HOLD_OFF_CYCLES);
        if (mismatches == 0 && pending_words == 0)
            $display("pixel_zero_suppress_framer_unit regression: pass");
        else
            $display("pixel_zero_suppress_framer_unit regression: fail");
        $finish;
    end

endmodule
